// File: design/tbvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tapered beam vertex setup: shared types and constants
// Fixed-point scales, clamp limits and the vertex order of one emitted run.
// ----------------------------------------------------------------------------
package tbvs_pkg;

  localparam int POS_SHIFT  = 18;
  localparam int CENTER_ONE = 16384;
  localparam int OPAC_MAX   = 255;
  localparam int ROOT_BITS  = 32;

  localparam logic [2:0] TRI_COUNT  = 3'd3;
  localparam logic [2:0] QUAD_COUNT = 3'd4;
  localparam logic [2:0] LAST_VERT  = 3'd6;

  typedef enum logic [2:0] {
    PT_START,
    PT_MID_L,
    PT_MID_R,
    PT_END_L,
    PT_END_R
  } point_t;

  typedef struct packed {
    logic       sel;
    logic [1:0] idx;
    point_t     pt;
  } vert_t;

  function automatic vert_t vert_of(input logic [2:0] k);
    vert_t v;
    case (k)
      3'd0:    v = '{sel: 1'b0, idx: 2'd0, pt: PT_START};
      3'd1:    v = '{sel: 1'b0, idx: 2'd1, pt: PT_MID_L};
      3'd2:    v = '{sel: 1'b0, idx: 2'd2, pt: PT_MID_R};
      3'd3:    v = '{sel: 1'b1, idx: 2'd0, pt: PT_MID_R};
      3'd4:    v = '{sel: 1'b1, idx: 2'd1, pt: PT_MID_L};
      3'd5:    v = '{sel: 1'b1, idx: 2'd2, pt: PT_END_L};
      3'd6:    v = '{sel: 1'b1, idx: 2'd3, pt: PT_END_R};
      default: v = '{sel: 1'b0, idx: 2'd0, pt: PT_START};
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/tapered_beam_vertex_setup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tapered beam vertex setup unit
// An accepted ray passes through every pipeline stage to its first vertex word.
// The seven-word output sequencer holds each non-dropped ray in the last stage until all
// its words are taken; the 40-stage pipeline itself takes a ray every cycle when not
// stalled, and the reciprocal square root resolves one bit of the root per stage.
// Reset clears all stage valid bits, the vertex counter and haze_start to 0.
// ----------------------------------------------------------------------------
module tapered_beam_vertex_setup_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [31:0]                 cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  signed [COORD_BITS-1:0] in_start_x,
  input  wire  signed [COORD_BITS-1:0] in_start_y,
  input  wire  signed [COORD_BITS-1:0] in_end_x,
  input  wire  signed [COORD_BITS-1:0] in_end_y,
  input  wire  [31:0]                 in_beam_color,
  input  wire  signed [15:0]          in_opacity_in,
  input  wire  signed [31:0]          in_depth_inv,
  input  wire  signed [15:0]          in_beam_width,
  input  wire  signed [15:0]          in_center_frac,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_polygon_sel,
  output logic [2:0]                  out_vertex_count,
  output logic [1:0]                  out_vertex_index,
  output logic signed [16:0]          out_vertex_x,
  output logic signed [16:0]          out_vertex_y,
  output logic signed [31:0]          out_vertex_depth,
  output logic [31:0]                 out_poly_color,
  output logic [7:0]                  out_poly_opacity,
  output logic                        out_haze_on,
  output logic                        out_run_last
);
  import tbvs_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int CW   = COORD_BITS + 16;
  localparam int PW   = COORD_BITS + 21;
  localparam int RB   = 4;
  localparam int SN   = RB + ROOT_BITS;
  localparam int NS   = SN + 4;
  localparam int LAST = NS - 1;

  localparam logic [65:0]        ROOT_LIM = 66'h1 << 62;
  localparam logic signed [63:0] MID_BIAS = (64'sd1 <<< 31) - 64'sd1;
  localparam logic signed [50:0] END_BIAS = (51'sd1 <<< 17) - 51'sd1;
  localparam logic signed [PW-1:0] POS_BIAS = (PW'(1) <<< POS_SHIFT) - PW'(1);

  typedef struct packed {
    logic                   drop;
    logic                   haze;
    logic [31:0]            color;
    logic signed [31:0]     depth;
    logic [7:0]             opac;
    logic [16:0]            w;
    logic [14:0]            c;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [17:0]     sdx;
    logic signed [17:0]     sdy;
    logic [33:0]            sqx;
    logic [33:0]            sqy;
    logic [34:0]            l2;
    logic [62:0]            p;
    logic [62:0]            q;
    logic [31:0]            r;
    logic signed [32:0]     sn;
    logic signed [32:0]     cs;
    logic [29:0]            mw;
    logic signed [CW-1:0]   dxc;
    logic signed [CW-1:0]   dyc;
    logic signed [63:0]     pox;
    logic signed [63:0]     poy;
    logic signed [50:0]     pex;
    logic signed [50:0]     pey;
    logic signed [PW-1:0]   mx;
    logic signed [PW-1:0]   my;
    logic signed [31:0]     ox;
    logic signed [31:0]     oy;
    logic signed [31:0]     ex;
    logic signed [31:0]     ey;
    logic [16:0]            v0x;
    logic [16:0]            v0y;
    logic [16:0]            mlx;
    logic [16:0]            mly;
    logic [16:0]            mrx;
    logic [16:0]            mry;
    logic [16:0]            elx;
    logic [16:0]            ely;
    logic [16:0]            erx;
    logic [16:0]            ery;
  } stage_t;

  stage_t             st_r   [NS];
  stage_t             st_nxt [NS];
  logic [NS-1:0]      v_r;
  logic [NS-1:0]      adv;
  logic [2:0]         k_r;
  logic signed [31:0] haze_start_r;
  vert_t              cur;

  function automatic logic [16:0] pos_to_pix(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] b;
    b = v + (v[PW-1] ? POS_BIAS : PW'(0));
    b = b >>> POS_SHIFT;
    return b[16:0];
  endfunction

  always_comb begin
    stage_t             t;
    logic signed [16:0] bw17;
    logic [DW-1:0]      adx;
    logic [DW-1:0]      ady;
    logic [DW-1:0]      m;
    logic [DW-1:0]      sx;
    logic [DW-1:0]      sy;
    logic [5:0]         sh;
    logic [96:0]        t3w;
    logic [65:0]        qs;
    logic [65:0]        cand;
    logic               ovf;
    logic signed [PW-1:0] x1p;
    logic signed [PW-1:0] y1p;
    logic signed [PW-1:0] ext;
    int                 k;

    for (int i = 1; i < NS; i++) begin
      st_nxt[i] = st_r[i-1];
    end

    t = '0;
    t.x0 = in_start_x;
    t.y0 = in_start_y;
    t.x1 = in_end_x;
    t.y1 = in_end_y;
    t.dx = DW'(in_end_x) - DW'(in_start_x);
    t.dy = DW'(in_end_y) - DW'(in_start_y);
    t.color = in_beam_color;
    t.depth = in_depth_inv;
    t.drop = (in_beam_color == 32'd0) || ((t.dx == '0) && (t.dy == '0));
    bw17 = 17'(in_beam_width);
    t.w = bw17[16] ? 17'(-bw17) : 17'(bw17);
    if (in_center_frac[15]) begin
      t.c = '0;
    end else if (in_center_frac > 16'(CENTER_ONE)) begin
      t.c = 15'(CENTER_ONE);
    end else begin
      t.c = in_center_frac[14:0];
    end
    if (in_opacity_in[15]) begin
      t.opac = '0;
    end else if (in_opacity_in > 16'(OPAC_MAX)) begin
      t.opac = 8'(OPAC_MAX);
    end else begin
      t.opac = in_opacity_in[7:0];
    end
    t.haze = in_depth_inv < haze_start_r;
    st_nxt[0] = t;

    t = st_r[0];
    adx = t.dx[DW-1] ? DW'(-t.dx) : DW'(t.dx);
    ady = t.dy[DW-1] ? DW'(-t.dy) : DW'(t.dy);
    m = adx | ady;
    sh = '0;
    for (int j = 0; j < DW; j++) begin
      if (m[j] && (j >= 17)) begin
        sh = 6'(j - 16);
      end
    end
    sx = adx >> sh;
    sy = ady >> sh;
    t.sdx = t.dx[DW-1] ? -18'(sx) : 18'(sx);
    t.sdy = t.dy[DW-1] ? -18'(sy) : 18'(sy);
    st_nxt[1] = t;

    t = st_r[1];
    t.sqx = 34'(36'(t.sdx) * 36'(t.sdx));
    t.sqy = 34'(36'(t.sdy) * 36'(t.sdy));
    st_nxt[2] = t;

    t = st_r[2];
    t.l2 = 35'(t.sqx) + 35'(t.sqy);
    t.p = '0;
    t.q = '0;
    t.r = '0;
    st_nxt[3] = t;

    for (int i = RB; i < SN; i++) begin
      k = ROOT_BITS - 1 - (i - RB);
      t = st_r[i-1];
      t3w = 97'(t.l2) << (2 * k);
      ovf = |t3w[96:63];
      qs = 66'(t.q) << (k + 1);
      cand = 66'(t.p) + qs + 66'(t3w[62:0]);
      if (!ovf && (cand <= ROOT_LIM)) begin
        t.p = 63'(cand);
        t.q = 63'(66'(t.q) + (66'(t.l2) << k));
        t.r = t.r | (32'd1 << k);
      end
      st_nxt[i] = t;
    end

    t = st_r[SN-1];
    t.sn = 33'(51'(t.sdy) * 51'($signed({1'b0, t.r})));
    t.cs = 33'(51'(t.sdx) * 51'($signed({1'b0, t.r})));
    t.mw = 30'(32'(t.w) * 32'(t.c));
    t.dxc = CW'(t.dx) * CW'($signed({1'b0, t.c}));
    t.dyc = CW'(t.dy) * CW'($signed({1'b0, t.c}));
    st_nxt[SN] = t;

    t = st_r[SN];
    t.pox = $signed(64'(t.mw)) * 64'(t.sn);
    t.poy = $signed(64'(t.mw)) * 64'(t.cs);
    t.pex = $signed(51'(t.w)) * 51'(t.sn);
    t.pey = $signed(51'(t.w)) * 51'(t.cs);
    t.mx = (PW'(t.x0) <<< POS_SHIFT) + (PW'(t.dxc) <<< 4);
    t.my = (PW'(t.y0) <<< POS_SHIFT) + (PW'(t.dyc) <<< 4);
    st_nxt[SN+1] = t;

    t = st_r[SN+1];
    t.ox = 32'((t.pox + (t.pox[63] ? MID_BIAS : 64'sd0)) >>> 31);
    t.oy = 32'((t.poy + (t.poy[63] ? MID_BIAS : 64'sd0)) >>> 31);
    t.ex = 32'((t.pex + (t.pex[50] ? END_BIAS : 51'sd0)) >>> 17);
    t.ey = 32'((t.pey + (t.pey[50] ? END_BIAS : 51'sd0)) >>> 17);
    st_nxt[SN+2] = t;

    t = st_r[SN+2];
    x1p = PW'(t.x1) <<< POS_SHIFT;
    y1p = PW'(t.y1) <<< POS_SHIFT;
    ext = PW'(t.x0);
    t.v0x = ext[16:0];
    ext = PW'(t.y0);
    t.v0y = ext[16:0];
    t.mlx = pos_to_pix(t.mx - PW'(t.ox));
    t.mly = pos_to_pix(t.my + PW'(t.oy));
    t.mrx = pos_to_pix(t.mx + PW'(t.ox));
    t.mry = pos_to_pix(t.my - PW'(t.oy));
    t.elx = pos_to_pix(x1p - PW'(t.ex));
    t.ely = pos_to_pix(y1p + PW'(t.ey));
    t.erx = pos_to_pix(x1p + PW'(t.ex));
    t.ery = pos_to_pix(y1p - PW'(t.ey));
    st_nxt[SN+3] = t;
  end

  always_comb begin
    adv[LAST] = !v_r[LAST] || st_r[LAST].drop || (out_ready && (k_r == LAST_VERT));
    for (int i = LAST - 1; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      haze_start_r <= '0;
    end else if (cfg_valid) begin
      haze_start_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (out_valid && out_ready) begin
      k_r <= (k_r == LAST_VERT) ? 3'd0 : k_r + 3'd1;
    end
  end

  always_comb begin
    cur = vert_of(k_r);
    out_valid        = v_r[LAST] && !st_r[LAST].drop;
    out_polygon_sel  = cur.sel;
    out_vertex_count = cur.sel ? QUAD_COUNT : TRI_COUNT;
    out_vertex_index = cur.idx;
    out_vertex_depth = st_r[LAST].depth;
    out_poly_color   = st_r[LAST].color;
    out_poly_opacity = st_r[LAST].opac;
    out_haze_on      = st_r[LAST].haze;
    out_run_last     = (k_r == LAST_VERT);
    case (cur.pt)
      PT_START: begin
        out_vertex_x = st_r[LAST].v0x;
        out_vertex_y = st_r[LAST].v0y;
      end
      PT_MID_L: begin
        out_vertex_x = st_r[LAST].mlx;
        out_vertex_y = st_r[LAST].mly;
      end
      PT_MID_R: begin
        out_vertex_x = st_r[LAST].mrx;
        out_vertex_y = st_r[LAST].mry;
      end
      PT_END_L: begin
        out_vertex_x = st_r[LAST].elx;
        out_vertex_y = st_r[LAST].ely;
      end
      PT_END_R: begin
        out_vertex_x = st_r[LAST].erx;
        out_vertex_y = st_r[LAST].ery;
      end
      default: begin
        out_vertex_x = st_r[LAST].v0x;
        out_vertex_y = st_r[LAST].v0y;
      end
    endcase
  end

endmodule
`default_nettype wire
